// ===== rtl/ccc_pkg.sv =====
// ============================================================================
// ccc_pkg: shared types and constants for the common character counter
// Command codes, field widths and the control/status bundles that join the
// controller and the datapath.
// ============================================================================
package ccc_pkg;

    localparam int CMD_W    = 2;
    localparam int SYM_W    = 8;
    localparam int COUNT_W  = 16;
    localparam int TOTAL_W  = 16;
    localparam int SYM_NUM  = 256;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIRST  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SECOND = 2'd2;

    localparam logic [31:0] MAX_COUNT_DEFAULT = 32'd65535;

    // Controller to datapath.
    typedef struct packed {
        logic accept;   // capture the incoming item and launch the count read
        logic exec;     // apply the update and load the output register
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic slot_free; // output register can take a result at this edge
    } dp_status_t;

endpackage

// ===== rtl/ccc_ram.sv =====
// ============================================================================
// ccc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module ccc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ccc_ctrl.sv =====
// ============================================================================
// ccc_ctrl: transaction sequencer
// Takes one input transaction, waits for the count read, then commits the
// update once the output register has room.
// ============================================================================
module ccc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ccc_pkg::dp_status_t status,
    output ccc_pkg::ctrl_cmd_t  ctrl
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        ctrl.accept = 1'b0;
        ctrl.exec   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctrl.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // The read data has arrived; hold here while the result
                // register is still occupied by an untaken transaction.
                if (status.slot_free)
                begin
                    ctrl.exec  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/ccc_datapath.sv =====
// ============================================================================
// ccc_datapath: count store, running total and result register
// Holds the per-byte counts in a RAM with one valid bit per entry, applies
// the increment or decrement and keeps the saturating shared total.
// ============================================================================
module ccc_datapath #(
    parameter logic [31:0] MAX_COUNT = ccc_pkg::MAX_COUNT_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ccc_pkg::ctrl_cmd_t          ctrl,
    output ccc_pkg::dp_status_t         status,
    input  logic [ccc_pkg::CMD_W-1:0]   cmd,
    input  logic [ccc_pkg::SYM_W-1:0]   symbol,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        matched,
    output logic [ccc_pkg::TOTAL_W-1:0] common_total
);

    localparam logic [ccc_pkg::COUNT_W-1:0] CntLimit =
        (MAX_COUNT > 32'd65535) ? 16'hFFFF : MAX_COUNT[ccc_pkg::COUNT_W-1:0];

    logic [ccc_pkg::CMD_W-1:0]   cmd_reg;
    logic [ccc_pkg::SYM_W-1:0]   sym_reg;
    logic [ccc_pkg::SYM_NUM-1:0] valid_bits_reg;
    logic [ccc_pkg::SYM_NUM-1:0] valid_bits_next;
    logic [ccc_pkg::TOTAL_W-1:0] total_reg;
    logic [ccc_pkg::TOTAL_W-1:0] total_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        matched_reg;
    logic [ccc_pkg::TOTAL_W-1:0] out_total_reg;

    logic [ccc_pkg::COUNT_W-1:0] rd_count;
    logic [ccc_pkg::COUNT_W-1:0] cur_count;
    logic [ccc_pkg::COUNT_W-1:0] wr_count;
    logic                        wr_en;
    logic                        hit;

    ccc_ram #(
        .WIDTH (ccc_pkg::COUNT_W),
        .DEPTH (ccc_pkg::SYM_NUM)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (sym_reg),
        .wr_data (wr_count),
        .rd_en   (ctrl.accept),
        .rd_addr (symbol),
        .rd_data (rd_count)
    );

    always_comb
    begin
        // An entry never written since the last clear reads as zero.
        cur_count       = valid_bits_reg[sym_reg] ? rd_count : '0;
        wr_count        = cur_count;
        wr_en           = 1'b0;
        hit             = 1'b0;
        valid_bits_next = valid_bits_reg;
        total_next      = total_reg;
        case (cmd_reg)
            ccc_pkg::CMD_CLEAR:
            begin
                valid_bits_next = '0;
                total_next      = '0;
            end
            ccc_pkg::CMD_FIRST:
            begin
                wr_en = 1'b1;
                if (cur_count < CntLimit)
                begin
                    wr_count = cur_count + 16'd1;
                end
                valid_bits_next[sym_reg] = 1'b1;
            end
            ccc_pkg::CMD_SECOND:
            begin
                if (cur_count != '0)
                begin
                    wr_en    = 1'b1;
                    wr_count = cur_count - 16'd1;
                    hit      = 1'b1;
                    valid_bits_next[sym_reg] = 1'b1;
                    if (total_reg != '1)
                    begin
                        total_next = total_reg + 16'd1;
                    end
                end
            end
            default:
            begin
                // Unused command leaves the counts, valid bits and total alone.
            end
        endcase
        wr_en = wr_en & ctrl.exec;

        if (ctrl.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign status.slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_bits_reg <= '0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (ctrl.exec)
            begin
                valid_bits_reg <= valid_bits_next;
                total_reg      <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            cmd_reg <= cmd;
            sym_reg <= symbol;
        end
        if (ctrl.exec)
        begin
            matched_reg   <= hit;
            out_total_reg <= total_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign matched      = matched_reg;
    assign common_total = out_total_reg;

endmodule

// ===== rtl/common_character_counter.sv =====
// ============================================================================
// common_character_counter: shared character count of two byte strings
// Top level joining the sequencer and the count datapath.
// ============================================================================
// Send a clear transaction, then the bytes of the first string, then the
// bytes of the second string; every transaction returns one result with the
// match flag and the running shared total. Each transaction first does the
// registered read of the 256-entry count RAM and then the modify-write of
// that entry, and a new input is taken only after the previous one has
// been committed. The output register lets the next transaction
// enter while a result waits; the commit stalls only if that register is
// still full. Clearing is immediate through per-entry valid bits, with no
// clearing pass after reset. Counts saturate at MAX_COUNT or 65535,
// whichever is smaller, and the total saturates at 65535.
module common_character_counter #(
    parameter logic [31:0] MAX_COUNT = ccc_pkg::MAX_COUNT_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ccc_pkg::CMD_W-1:0]   cmd,
    input  logic [ccc_pkg::SYM_W-1:0]   symbol,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        matched,
    output logic [ccc_pkg::TOTAL_W-1:0] common_total
);

    ccc_pkg::ctrl_cmd_t  ctrl;
    ccc_pkg::dp_status_t status;

    ccc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .ctrl     (ctrl)
    );

    ccc_datapath #(
        .MAX_COUNT (MAX_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .status       (status),
        .cmd          (cmd),
        .symbol       (symbol),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .matched      (matched),
        .common_total (common_total)
    );

endmodule

// ===== rtl/ccc_checker.sv =====
// ============================================================================
// ccc_checker: port-level checks for the common character counter
// Watches the top-level handshakes and result fields over time.
// ============================================================================
module ccc_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [ccc_pkg::CMD_W-1:0]   cmd,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic                        matched,
    input  logic [ccc_pkg::TOTAL_W-1:0] common_total
);

    // Only one transaction is in flight, so input is refused right after one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted on consecutive cycles");

    // A stalled result must not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(matched)
                                       && $stable(common_total)))
        else $error("stalled result changed");

    // A clear transaction reports an empty total and no match.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && cmd == ccc_pkg::CMD_CLEAR)
            ##1 (!out_valid || out_ready)
        |=> (out_valid && !matched && common_total == '0))
        else $error("clear transaction did not report zero");

    // A match always leaves a nonzero shared total.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && matched) |-> (common_total != '0))
        else $error("match reported with zero total");

endmodule

bind common_character_counter ccc_checker u_ccc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .matched      (matched),
    .common_total (common_total)
);
